[hw/rtl/octave_value_noise_2d_unit_assert.svh]
// Assertion macros for the octave value noise unit.
// Used by the port checker; no other dependencies.
`ifndef OCTAVE_VALUE_NOISE_2D_UNIT_ASSERT_SVH
`define OCTAVE_VALUE_NOISE_2D_UNIT_ASSERT_SVH

// implication checked out of reset
`define OVN_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also active during reset
`define OVN_ASSERT_NXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/ovn2d_pkg.sv]
// Shared constants and types for the octave value noise unit.
// No dependencies.
`timescale 1ns / 1ps
package ovn2d_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int COS_DEPTH_DEF   = 256;
  localparam int MAX_OCT_DEF     = 4;

  localparam int COORD_W    = 24;
  localparam int NOISE_W    = 20;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;
  localparam int OCT_W      = 3;
  localparam int WGT_W      = 17;
  localparam int LAT_W      = 32;
  localparam int SM_W       = 36;
  localparam int ACC_W      = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE  = 4'd1;
  localparam logic [2:0] OCT_CNT_RESET = 3'd4;
  localparam logic [1:0] PERS_RESET    = 2'd1;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam logic [31:0] HASH_K1    = 32'd15731;
  localparam logic [31:0] HASH_K2    = 32'd789221;
  localparam logic [31:0] HASH_K3    = 32'd1376312589;
  localparam logic signed [LAT_W-1:0] ONE_Q30 = 32'sd1073741824;

  localparam logic signed [ACC_W-1:0] OUT_MAX = 24'sd524287;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -24'sd524288;

  // clocks from the accept edge to the edge that sees a one-octave result
  localparam int LAT_CYCLES = 13;

  typedef struct packed {
    logic             last;
    logic             zero;
    logic [OCT_W-1:0] oct;
  } ovn_meta_t;

endpackage

[hw/rtl/octave_value_noise_2d_unit.sv]
// Octave value noise unit: 13-stage pipeline, one octave per clock.
// Busy holds while octaves issue; a new item is taken once busy drops, while earlier ones are still in flight.
// All 16 lattice hashes run in parallel lanes and are reused for each octave.
// Reset (rst_n low, synchronous) clears valid bits, restores config and sequencer regs.
// Depends on ovn2d_pkg.
`timescale 1ns / 1ps
module octave_value_noise_2d_unit #(
  parameter int FRAC_BITS       = ovn2d_pkg::FRAC_BITS_DEF,
  parameter int COS_TABLE_DEPTH = ovn2d_pkg::COS_DEPTH_DEF,
  parameter int MAX_OCTAVES     = ovn2d_pkg::MAX_OCT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ovn2d_pkg::COORD_W-1:0]   in_coord_x,
  input  logic signed [ovn2d_pkg::COORD_W-1:0]   in_coord_y,
  output logic                                   out_valid,
  output logic signed [ovn2d_pkg::NOISE_W-1:0]   out_noise_value,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [ovn2d_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ovn2d_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import ovn2d_pkg::*;

  localparam int CW   = $clog2(MAX_OCTAVES + 1);
  localparam int OW   = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int SW   = COORD_W + MAX_OCTAVES - 1;
  localparam int IW   = $clog2(COS_TABLE_DEPTH);
  localparam int PW   = FRAC_BITS + IW + 1;
  localparam int NSTG = 12;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned ONE_U  = 64'd1073741824;

  function automatic longint cos_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    x2 = (x * x) >> 30;
    t  = ONE_U;
    s  = longint'(ONE_U);
    t = ((t * x2) >> 30) / 2;   s = s - longint'(t);
    t = ((t * x2) >> 30) / 12;  s = s + longint'(t);
    t = ((t * x2) >> 30) / 30;  s = s - longint'(t);
    t = ((t * x2) >> 30) / 56;  s = s + longint'(t);
    t = ((t * x2) >> 30) / 90;  s = s - longint'(t);
    t = ((t * x2) >> 30) / 132; s = s + longint'(t);
    t = ((t * x2) >> 30) / 182; s = s - longint'(t);
    t = ((t * x2) >> 30) / 240; s = s + longint'(t);
    return s;
  endfunction

  function automatic logic [WGT_W-1:0] cos_wt(input int idx);
    longint unsigned th;
    longint          c;
    longint          d;
    th = (PI_Q30 * longint'(idx)) / COS_TABLE_DEPTH;
    if (th <= PI_Q30 / 2) begin
      c = cos_q30(th);
    end else begin
      c = -cos_q30(PI_Q30 - th);
    end
    d = longint'(ONE_U) - c;
    if (d < 0) begin
      d = 0;
    end
    if (d > 2 * longint'(ONE_U)) begin
      d = 2 * longint'(ONE_U);
    end
    return WGT_W'(((longint'(d) << 16) + longint'(ONE_U)) >>> 31);
  endfunction

  logic [WGT_W-1:0] cos_lut [COS_TABLE_DEPTH];
  for (genvar gl = 0; gl < COS_TABLE_DEPTH; gl++) begin : g_lut
    assign cos_lut[gl] = cos_wt(gl);
  end

  // config registers
  logic [2:0] oct_cnt_r;
  logic [1:0] pers_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= OCT_CNT_RESET;
      pers_r    <= PERS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OCTAVE_COUNT: oct_cnt_r <= cfg_data[2:0];
        CFG_PERSISTENCE:  pers_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // octave sequencer
  logic                      busy_r;
  logic [OW-1:0]             seq_oct_r;
  logic [CW-1:0]             cnt_r;
  logic signed [COORD_W-1:0] x_r, y_r;
  logic [CW-1:0]             cfg_cnt;
  logic                      acc_in, iss_valid, iss_zero, iss_last;
  logic [CW-1:0]             iss_cnt;
  logic [OW-1:0]             iss_oct;
  logic signed [COORD_W-1:0] iss_c [2];

  assign cfg_cnt   = ({1'b0, oct_cnt_r} > 4'(MAX_OCTAVES)) ? CW'(MAX_OCTAVES) : CW'(oct_cnt_r);
  assign acc_in    = start & ~busy_r;
  assign iss_valid = acc_in | busy_r;
  assign iss_cnt   = busy_r ? cnt_r : cfg_cnt;
  assign iss_oct   = busy_r ? seq_oct_r : '0;
  assign iss_c[0]  = busy_r ? x_r : in_coord_x;
  assign iss_c[1]  = busy_r ? y_r : in_coord_y;
  assign iss_zero  = (iss_cnt == '0);
  assign iss_last  = iss_zero || ((CW + 1)'(iss_oct) + (CW + 1)'(1) == (CW + 1)'(iss_cnt));
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      seq_oct_r <= '0;
    end else if (busy_r) begin
      if (iss_last) begin
        busy_r <= 1'b0;
      end else begin
        seq_oct_r <= seq_oct_r + OW'(1);
      end
    end else if (acc_in && !iss_last) begin
      busy_r    <= 1'b1;
      seq_oct_r <= OW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      x_r   <= in_coord_x;
      y_r   <= in_coord_y;
      cnt_r <= cfg_cnt;
    end
  end

  // stage 0: scale by 2^i and split toward zero
  logic [31:0]          sp_u [2];
  logic [FRAC_BITS-1:0] sp_f [2];

  for (genvar ga = 0; ga < 2; ga++) begin : g_split
    logic signed [SW-1:0] sc;
    logic [SW-1:0]        mag;
    assign sc       = SW'(iss_c[ga]) <<< iss_oct;
    assign mag      = sc[SW-1] ? SW'(-sc) : SW'(sc);
    assign sp_f[ga] = mag[FRAC_BITS-1:0];
    assign sp_u[ga] = sc[SW-1] ? -32'(mag >> FRAC_BITS) : 32'(mag >> FRAC_BITS);
  end

  logic      vld_r  [NSTG];
  ovn_meta_t meta_r [NSTG];
  logic [31:0]          p0_u_r [2];
  logic [FRAC_BITS-1:0] p0_f_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else begin
      vld_r[0] <= iss_valid;
      for (int k = 1; k < NSTG; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    meta_r[0] <= '{last: iss_last, zero: iss_zero, oct: OCT_W'(iss_oct)};
    for (int k = 1; k < NSTG; k++) begin
      meta_r[k] <= meta_r[k-1];
    end
    p0_u_r <= sp_u;
    p0_f_r <= sp_f;
  end

  // stage 1: cosine weights
  logic [WGT_W-1:0] wx_r [1:7];
  logic [WGT_W-1:0] wy_r [1:9];
  logic [PW-1:0]    wi_x, wi_y;

  assign wi_x = PW'(p0_f_r[0]) * PW'(COS_TABLE_DEPTH);
  assign wi_y = PW'(p0_f_r[1]) * PW'(COS_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    wx_r[1] <= cos_lut[wi_x[FRAC_BITS +: IW]];
    wy_r[1] <= cos_lut[wi_y[FRAC_BITS +: IW]];
    for (int k = 2; k <= 7; k++) begin
      wx_r[k] <= wx_r[k-1];
    end
    for (int k = 2; k <= 9; k++) begin
      wy_r[k] <= wy_r[k-1];
    end
  end

  // stages 1..5: sixteen lattice hash lanes
  logic [31:0]              n1_r [16];
  logic [31:0]              n2_r [16];
  logic [31:0]              n3_r [16];
  logic [31:0]              m1_r [16];
  logic [31:0]              t_r  [16];
  logic [31:0]              m2_r [16];
  logic signed [LAT_W-1:0]  lat_r [16];

  for (genvar g = 0; g < 16; g++) begin : g_hash
    logic [31:0] pt;
    logic [31:0] hv;
    assign pt = (p0_u_r[0] + 32'(g / 4) - 32'd1)
              + (p0_u_r[1] + 32'(g % 4) - 32'd1) * HASH_MUL_Y;
    assign hv = m2_r[g] + HASH_K3;
    always_ff @(posedge clk) begin
      n1_r[g]  <= pt ^ (pt << 13);
      n2_r[g]  <= n1_r[g];
      m1_r[g]  <= n1_r[g] * n1_r[g];
      n3_r[g]  <= n2_r[g];
      t_r[g]   <= m1_r[g] * HASH_K1 + HASH_K2;
      m2_r[g]  <= n3_r[g] * t_r[g];
      lat_r[g] <= ONE_Q30 - $signed({1'b0, hv[30:0]});
    end
  end

  // stages 6..7: 3x3 smoothing for the four cell corners
  logic signed [LAT_W+1:0] cs_r [4];
  logic signed [LAT_W+1:0] ss_r [4];
  logic signed [LAT_W-1:0] ce_r [4];
  logic signed [SM_W-1:0]  v_r  [4];

  for (genvar gk = 0; gk < 4; gk++) begin : g_smooth
    localparam int CX = gk % 2;
    localparam int CY = gk / 2;
    always_ff @(posedge clk) begin
      cs_r[gk] <= 34'(lat_r[CX*4 + CY]) + 34'(lat_r[(CX+2)*4 + CY])
                + 34'(lat_r[CX*4 + CY + 2]) + 34'(lat_r[(CX+2)*4 + CY + 2]);
      ss_r[gk] <= 34'(lat_r[CX*4 + CY + 1]) + 34'(lat_r[(CX+2)*4 + CY + 1])
                + 34'(lat_r[(CX+1)*4 + CY]) + 34'(lat_r[(CX+1)*4 + CY + 2]);
      ce_r[gk] <= lat_r[(CX+1)*4 + CY + 1];
      v_r[gk]  <= SM_W'(cs_r[gk]) + (SM_W'(ss_r[gk]) <<< 1) + (SM_W'(ce_r[gk]) <<< 2);
    end
  end

  // stages 8..11: blend rows on x, then on y
  logic signed [17:0]        wxc, wxs, wyc, wys;
  logic signed [SM_W+17:0]   pa_r [2];
  logic signed [SM_W+17:0]   pb_r [2];
  logic signed [SM_W-1:0]    r_r  [2];
  logic signed [SM_W+17:0]   qa_r, qb_r;
  logic signed [SM_W-1:0]    ov_r;
  logic signed [SM_W+18:0]   rs0, rs1, qs;

  assign wxs = $signed({1'b0, wx_r[7]});
  assign wxc = 18'sd65536 - wxs;
  assign wys = $signed({1'b0, wy_r[9]});
  assign wyc = 18'sd65536 - wys;
  assign rs0 = (SM_W + 19)'(pa_r[0]) + (SM_W + 19)'(pb_r[0]);
  assign rs1 = (SM_W + 19)'(pa_r[1]) + (SM_W + 19)'(pb_r[1]);
  assign qs  = (SM_W + 19)'(qa_r) + (SM_W + 19)'(qb_r);

  always_ff @(posedge clk) begin
    pa_r[0] <= (SM_W + 18)'(v_r[0]) * (SM_W + 18)'(wxc);
    pb_r[0] <= (SM_W + 18)'(v_r[1]) * (SM_W + 18)'(wxs);
    pa_r[1] <= (SM_W + 18)'(v_r[2]) * (SM_W + 18)'(wxc);
    pb_r[1] <= (SM_W + 18)'(v_r[3]) * (SM_W + 18)'(wxs);
    r_r[0]  <= SM_W'(rs0 >>> 16);
    r_r[1]  <= SM_W'(rs1 >>> 16);
    qa_r    <= (SM_W + 18)'(r_r[0]) * (SM_W + 18)'(wyc);
    qb_r    <= (SM_W + 18)'(r_r[1]) * (SM_W + 18)'(wys);
    ov_r    <= SM_W'(qs >>> 16);
  end

  // output stage: weight, accumulate, saturate
  logic [5:0]              shamt;
  logic signed [ACC_W-1:0] scaled, sum, acc_r;
  logic                    out_valid_r;
  logic signed [NOISE_W-1:0] out_noise_r;
  ovn_meta_t               mo;

  assign mo     = meta_r[NSTG-1];
  assign shamt  = 6'd18 + 6'(pers_r) * 6'(mo.oct);
  assign scaled = mo.zero ? '0 : ACC_W'(ov_r >>> shamt);
  assign sum    = (mo.oct == '0) ? scaled : acc_r + scaled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[NSTG-1] & mo.last;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r[NSTG-1]) begin
      acc_r <= sum;
      if (sum > OUT_MAX) begin
        out_noise_r <= NOISE_W'(OUT_MAX);
      end else if (sum < OUT_MIN) begin
        out_noise_r <= NOISE_W'(OUT_MIN);
      end else begin
        out_noise_r <= NOISE_W'(sum);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_r;

endmodule

[hw/rtl/ovn2d_checker.sv]
// Port-level checker for the octave value noise unit, bound to the top level.
// Depends on ovn2d_pkg and octave_value_noise_2d_unit_assert.svh.
`timescale 1ns / 1ps
`include "octave_value_noise_2d_unit_assert.svh"
module ovn2d_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import ovn2d_pkg::*;

  `OVN_ASSERT_IMP(a_busy_rise, clk, rst_n, $rose(busy), $past(start), "busy rose without start")
  `OVN_ASSERT_IMP(a_one_oct_lat, clk, rst_n, start && !busy ##1 !busy, ##(LAT_CYCLES-1) out_valid, "single-octave word missed its latency")
  `OVN_ASSERT_NXT(a_reset, clk, !rst_n, !busy && !out_valid, "busy or strobe out of reset")

endmodule

bind octave_value_noise_2d_unit ovn2d_checker u_ovn2d_checker (.*);
